FILE: hdl/alrdb_pkg.sv
// alrdb_pkg: types and constants shared by the audio level raster blocks
// holds the channel words, the command codes and the executor state encoding
// no dependencies
package alrdb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int PADDR_IN_W = 14;
    localparam int PIXEL_W    = 8;
    localparam int SEQ_W      = 32;
    localparam int SPP_W      = 8;

    // grey scale: largest v with v*v*2^15 <= 65025*peak
    localparam logic [16:0] GREY_SCALE = 17'd65025;
    localparam int          GREY_SHIFT = 15;

    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int   PADDR_W               = 3;
    localparam logic REG_SAMPLES_PER_PIXEL = 1'b0;
    localparam logic [7:0] SPP_RESET       = 8'd1;

    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_POLL    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_READ    = 2'd3
    } alrdb_func_t;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [SAMPLE_W-1:0]   sample;
        logic [PADDR_IN_W-1:0]        pixel_address;
    } alrdb_in_t;

    typedef struct packed {
        logic                 published;
        logic                 complete;
        logic [SEQ_W-1:0]     sequence_res;
        logic [PIXEL_W-1:0]   pixel_value;
    } alrdb_out_t;

    // classified command handed from the front to the executor
    typedef struct packed {
        alrdb_func_t            func;
        logic [MAG_W-1:0]       mag;
        logic [PADDR_IN_W-1:0]  pixel_address;
    } alrdb_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR      = 4'd0,
        ST_IDLE       = 4'd1,
        ST_EXEC       = 4'd2,
        ST_GREY_LIM   = 4'd3,
        ST_GREY_STEP  = 4'd4,
        ST_COPY       = 4'd5,
        ST_COPY_LAST  = 4'd6,
        ST_READ_WAIT  = 4'd7,
        ST_FINISH     = 4'd8
    } alrdb_state_t;

endpackage

FILE: hdl/audio_level_raster_double_buffer.sv
// audio_level_raster_double_buffer: top level with the register port,
// front classifier, command queue and raster executor
// depends on alrdb_pkg, alrdb_front, alrdb_queue, alrdb_back, alrdb_ram
//
//   channel  | handshake                 | word
//   ---------+---------------------------+------------------------------------
//   item     | item_valid / item_stall   | func, sample, pixel_address
//   result   | result_valid / result_stall | published, complete, sequence_res,
//            |                           | pixel_value
//   config   | psel/penable/pwrite/pready| samples_per_pixel at byte address 0
//
// a word passes ST_IDLE, ST_EXEC and ST_FINISH in the executor, plus ST_READ_WAIT for an
// in-range pixel read, ST_GREY_LIM and ST_GREY_STEP when it closes a pixel (one multiply
// plus an 8 step grey search), and ST_COPY and ST_COPY_LAST when a poll copies the raster
// (one byte per cycle through the back ram read port); after reset both rasters are swept
// to zero with item_stall high; the two entry queue lets the front take words while
// the executor works or waits on result_stall
module audio_level_raster_double_buffer
    import alrdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 126,
    parameter int IMAGE_HEIGHT = 64,
    parameter int ROW_STRIDE   = 132
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  alrdb_in_t           item,
    output logic                result_valid,
    input  logic                result_stall,
    output alrdb_out_t          result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SPP_W-1:0] spp_reg, spp_next;
    logic             cfg_write;
    logic             q_push, q_pop, q_full, q_valid, clearing;
    alrdb_cmd_t       q_entry, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_SAMPLES_PER_PIXEL);
    assign spp_next  = cfg_write ? pwdata[SPP_W-1:0] : spp_reg;
    assign prdata    = (paddr[2] == REG_SAMPLES_PER_PIXEL) ? {24'd0, spp_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= SPP_RESET;
        end
        else
        begin
            spp_reg <= spp_next;
        end
    end

    alrdb_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    alrdb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    alrdb_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .ROW_STRIDE   (ROW_STRIDE)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .samples_per_pixel (spp_reg),
        .q_valid           (q_valid),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .clearing          (clearing),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result)
    );

    // a complete frame is only ever reported by a successful poll
    a_complete_published: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.complete |-> result.published)
        else $error("complete without published");

    // pixel data and a publish never share one result word
    a_pixel_not_poll: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.published |-> result.pixel_value == '0)
        else $error("pixel value on a poll result");

    // no word enters while the rasters are being cleared
    a_stall_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> item_stall && !q_pop)
        else $error("word taken during clearing sweep");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && !q_pop |=> !q_push || q_full == 1'b0)
        else $error("queue overflow");

endmodule

FILE: hdl/alrdb_ram.sv
// alrdb_ram: generic single write port, single read port memory
// read data is registered; no reset on the storage
// no dependencies
module alrdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8448
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/alrdb_front.sv
// alrdb_front: accepts input words, classifies the function code and
// takes the sample magnitude; depends on alrdb_pkg
module alrdb_front
    import alrdb_pkg::*;
(
    input  logic        item_valid,
    output logic        item_stall,
    input  alrdb_in_t   item,
    input  logic        q_full,
    input  logic        clearing,
    output logic        q_push,
    output alrdb_cmd_t  q_entry
);

    logic [MAG_W-1:0] ext;

    // no words while the rasters are swept after reset
    assign item_stall = q_full | clearing;
    assign q_push     = item_valid & ~item_stall;

    assign ext = {item.sample[SAMPLE_W-1], item.sample};

    always_comb
    begin
        q_entry.func          = alrdb_func_t'(item.func);
        q_entry.pixel_address = item.pixel_address;
        // two's complement magnitude, -32768 maps to 32768
        if (item.sample[SAMPLE_W-1])
        begin
            q_entry.mag = MAG_W'(0) - ext;
        end
        else
        begin
            q_entry.mag = ext;
        end
    end

endmodule

FILE: hdl/alrdb_queue.sv
// alrdb_queue: short command queue between the front and the executor
// depends on alrdb_pkg
module alrdb_queue
    import alrdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  alrdb_cmd_t  push_entry,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output alrdb_cmd_t  head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    alrdb_cmd_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/alrdb_back.sv
// alrdb_back: executes queued commands against the back and front rasters
// holds the frame state, the grey converter, the copy sweep and the result register
// depends on alrdb_pkg and alrdb_ram
module alrdb_back
    import alrdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 126,
    parameter int IMAGE_HEIGHT = 64,
    parameter int ROW_STRIDE   = 132
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SPP_W-1:0]  samples_per_pixel,
    input  logic              q_valid,
    input  alrdb_cmd_t        q_head,
    output logic              q_pop,
    output logic              clearing,
    output logic              result_valid,
    input  logic              result_stall,
    output alrdb_out_t        result
);

    localparam int RASTER_BYTES = ROW_STRIDE * IMAGE_HEIGHT;
    localparam int RASTER_AW    = (RASTER_BYTES > 1) ? $clog2(RASTER_BYTES) : 1;
    localparam int POS_W        = $clog2(RASTER_BYTES + IMAGE_WIDTH + 1);
    localparam int COL_W        = $clog2(IMAGE_WIDTH + 1);
    localparam int ROW_W        = $clog2(IMAGE_HEIGHT + 1);
    localparam int RDA_W        = (PADDR_IN_W > RASTER_AW) ? PADDR_IN_W + 1 : RASTER_AW + 1;
    localparam logic [RASTER_AW-1:0] LAST_ADDR = RASTER_AW'(RASTER_BYTES - 1);

    alrdb_state_t state_reg, state_next;

    alrdb_cmd_t            cur_reg, cur_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [POS_W-1:0]      base_reg, base_next;
    logic [SPP_W-1:0]      cnt_reg, cnt_next;
    logic [MAG_W-1:0]      peak_reg, peak_next;
    logic                  changed_reg, changed_next;
    logic                  borrowed_reg, borrowed_next;
    logic                  done_reg, done_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;

    logic [MAG_W-1:0]      grey_peak_reg, grey_peak_next;
    logic [POS_W-1:0]      wr_pos_reg, wr_pos_next;
    logic                  wr_ok_reg, wr_ok_next;
    logic [31:0]           limit_reg, limit_next;
    logic [PIXEL_W-1:0]    v_reg, v_next;
    logic [2:0]            bit_reg, bit_next;

    logic [RASTER_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [RASTER_AW-1:0]  cp_addr_reg, cp_addr_next;
    logic [RASTER_AW-1:0]  cp_wr_reg, cp_wr_next;
    logic                  cp_pend_reg, cp_pend_next;
    logic                  cp_clear_reg, cp_clear_next;

    alrdb_out_t            res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    alrdb_out_t            out_reg, out_next;

    logic                  out_free;
    logic [SPP_W-1:0]      cnt_inc;
    logic [MAG_W-1:0]      peak_max;
    logic                  pixel_due;
    logic                  grant;
    logic                  rd_in_range;
    logic [POS_W-1:0]      pos;
    logic [COL_W-1:0]      col_inc;
    logic [ROW_W-1:0]      row_inc;
    logic [PIXEL_W-1:0]    trial;
    logic [15:0]           trial_sq;
    logic [31:0]           trial_cand;
    logic [PIXEL_W-1:0]    v_fin;

    logic                  back_we, front_we;
    logic [RASTER_AW-1:0]  back_waddr, front_waddr;
    logic [PIXEL_W-1:0]    back_wdata, front_wdata;
    logic [PIXEL_W-1:0]    back_rdata, front_rdata;

    alrdb_ram #(.WIDTH(PIXEL_W), .DEPTH(RASTER_BYTES)) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (cp_addr_reg),
        .rdata (back_rdata)
    );

    alrdb_ram #(.WIDTH(PIXEL_W), .DEPTH(RASTER_BYTES)) u_front_ram (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (RASTER_AW'(cur_reg.pixel_address)),
        .rdata (front_rdata)
    );

    assign out_free     = ~out_valid_reg | ~result_stall;
    assign q_pop        = (state_reg == ST_IDLE) & q_valid;
    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign cnt_inc     = cnt_reg + 1'b1;
    assign peak_max    = (cur_reg.mag > peak_reg) ? cur_reg.mag : peak_reg;
    assign pixel_due   = ~(cnt_inc < samples_per_pixel);
    assign grant       = ~borrowed_reg & changed_reg;
    assign rd_in_range = RDA_W'(cur_reg.pixel_address) < RDA_W'(RASTER_BYTES);
    assign pos         = base_reg + POS_W'(col_reg);
    assign col_inc     = col_reg + 1'b1;
    assign row_inc     = row_reg + 1'b1;

    // one bit of the grey value per step
    assign trial      = v_reg | (PIXEL_W'(1) << bit_reg);
    assign trial_sq   = 16'(trial) * 16'(trial);
    assign trial_cand = {1'b0, trial_sq, 15'd0};
    assign v_fin      = (trial_cand <= limit_reg) ? trial : v_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cur_reg.func)
                    FUNC_SAMPLE:  state_next = pixel_due ? ST_GREY_LIM : ST_FINISH;
                    FUNC_POLL:    state_next = grant ? ST_COPY : ST_FINISH;
                    FUNC_READ:    state_next = rd_in_range ? ST_READ_WAIT : ST_FINISH;
                    default:      state_next = ST_FINISH;
                endcase
            end
            ST_GREY_LIM:  state_next = ST_GREY_STEP;
            ST_GREY_STEP:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COPY:
            begin
                if (cp_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_COPY_LAST;
                end
            end
            ST_COPY_LAST: state_next = ST_FINISH;
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cur_next       = cur_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        peak_next      = peak_reg;
        changed_next   = changed_reg;
        borrowed_next  = borrowed_reg;
        done_next      = done_reg;
        seq_next       = seq_reg;
        grey_peak_next = grey_peak_reg;
        wr_pos_next    = wr_pos_reg;
        wr_ok_next     = wr_ok_reg;
        limit_next     = limit_reg;
        v_next         = v_reg;
        bit_next       = bit_reg;
        clr_addr_next  = clr_addr_reg;
        cp_addr_next   = cp_addr_reg;
        cp_wr_next     = cp_addr_reg;
        cp_pend_next   = (state_reg == ST_COPY);
        cp_clear_next  = cp_clear_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        back_we     = 1'b0;
        back_waddr  = cp_wr_reg;
        back_wdata  = '0;
        front_we    = cp_pend_reg;
        front_waddr = cp_wr_reg;
        front_wdata = back_rdata;

        if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        // trailing write of the copy sweep, clearing the back raster behind it when the frame was complete
        if (cp_pend_reg && cp_clear_reg)
        begin
            back_we = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                back_we       = 1'b1;
                back_waddr    = clr_addr_reg;
                front_we      = 1'b1;
                front_waddr   = clr_addr_reg;
                front_wdata   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cur_next = q_head;
            end
            ST_EXEC:
            begin
                res_next = '0;
                case (cur_reg.func)
                    FUNC_SAMPLE:
                    begin
                        if (!pixel_due)
                        begin
                            peak_next = peak_max;
                            cnt_next  = cnt_inc;
                        end
                        else
                        begin
                            grey_peak_next = peak_max;
                            peak_next      = '0;
                            cnt_next       = '0;
                            changed_next   = 1'b1;
                            wr_pos_next    = pos;
                            wr_ok_next     = pos < POS_W'(RASTER_BYTES);
                            if (col_inc == COL_W'(IMAGE_WIDTH))
                            begin
                                col_next = '0;
                                if (row_inc == ROW_W'(IMAGE_HEIGHT))
                                begin
                                    row_next  = '0;
                                    base_next = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    row_next  = row_inc;
                                    base_next = base_reg + POS_W'(ROW_STRIDE);
                                end
                            end
                            else
                            begin
                                col_next = col_inc;
                            end
                        end
                    end
                    FUNC_POLL:
                    begin
                        if (grant)
                        begin
                            changed_next       = 1'b0;
                            borrowed_next      = 1'b1;
                            cp_addr_next       = '0;
                            cp_clear_next      = done_reg;
                            res_next.published = 1'b1;
                            res_next.complete  = done_reg;
                            res_next.sequence_res = done_reg ? seq_reg + 1'b1 : seq_reg;
                            if (done_reg)
                            begin
                                done_next = 1'b0;
                                seq_next  = seq_reg + 1'b1;
                                col_next  = '0;
                                row_next  = '0;
                                base_next = '0;
                                cnt_next  = '0;
                                peak_next = '0;
                            end
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        borrowed_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_GREY_LIM:
            begin
                limit_next = {15'd0, grey_peak_reg} * 32'(GREY_SCALE);
                v_next     = '0;
                bit_next   = 3'd7;
            end
            ST_GREY_STEP:
            begin
                v_next   = v_fin;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 3'd0 && wr_ok_reg)
                begin
                    back_we    = 1'b1;
                    back_waddr = RASTER_AW'(wr_pos_reg);
                    back_wdata = v_fin;
                end
            end
            ST_COPY:
            begin
                cp_addr_next = cp_addr_reg + 1'b1;
            end
            ST_READ_WAIT:
            begin
                res_next.pixel_value = front_rdata;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            changed_reg   <= 1'b0;
            borrowed_reg  <= 1'b0;
            done_reg      <= 1'b0;
            seq_reg       <= '0;
            clr_addr_reg  <= '0;
            cp_pend_reg   <= 1'b0;
            cp_clear_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            peak_reg      <= peak_next;
            changed_reg   <= changed_next;
            borrowed_reg  <= borrowed_next;
            done_reg      <= done_next;
            seq_reg       <= seq_next;
            clr_addr_reg  <= clr_addr_next;
            cp_pend_reg   <= cp_pend_next;
            cp_clear_reg  <= cp_clear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        grey_peak_reg <= grey_peak_next;
        wr_pos_reg    <= wr_pos_next;
        wr_ok_reg     <= wr_ok_next;
        limit_reg     <= limit_next;
        v_reg         <= v_next;
        bit_reg       <= bit_next;
        cp_addr_reg   <= cp_addr_next;
        cp_wr_reg     <= cp_wr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule
